// ===== sv/ibvp_pkg.sv =====
package ibvp_pkg;

  localparam int NUM_BLOCKS_DFLT = 32;

  localparam int LEN_W    = 31;
  localparam int CNT_W    = 32;
  localparam int TOT_W    = 48;
  localparam int ID_W     = 5;
  localparam int SIZE_W   = 8;

  localparam logic [LEN_W-1:0] INTERVAL_LEN_RST = 31'd1000000;

  localparam logic CMD_BLOCK = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic KIND_HIT     = 1'b0;
  localparam logic KIND_TRAILER = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CHECK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_TRAIL
  } state_t;

  // Access strobes from the sequencer to the hit counter store
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } hit_ctl_t;

endpackage

// ===== sv/ibvp_hits.sv =====
module ibvp_hits #(
  parameter int NUM_BLOCKS = ibvp_pkg::NUM_BLOCKS_DFLT,
  parameter int AW         = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ibvp_pkg::hit_ctl_t           ctl,
  input  logic [AW-1:0]                addr,
  input  logic [ibvp_pkg::CNT_W-1:0]   wr_data,
  output logic [ibvp_pkg::CNT_W-1:0]   rd_data
);

  logic [ibvp_pkg::CNT_W-1:0] mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0]      vld;
  logic [ibvp_pkg::CNT_W-1:0] rd_q;
  logic                       rd_vld;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_q <= mem[addr];
    end
  end

  // Valid bits stand in for a cleared store: dump clears by dropping the bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctl.wr) begin
        vld[addr] <= 1'b1;
      end else if (ctl.clr) begin
        vld[addr] <= 1'b0;
      end
      if (ctl.rd) begin
        rd_vld <= vld[addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ===== sv/interval_block_vector_profiler_top.sv =====
// Block command: read in IDLE, add in ADD, threshold check in CHECK; IDLE then
// takes the next request. An out-of-range block id is dropped in IDLE.
// Dump (flush from IDLE, or interval full in CHECK): SCAN_RD then SCAN_CHK for
// each counter in the single-port hit store, then TRAIL. SCAN_CHK loads a hit
// record for a nonzero counter, TRAIL the trailer; both wait on back-pressure.
// Synchronous reset clears all counters and totals; interval_length = 1000000.
module interval_block_vector_profiler_top #(
  parameter int NUM_BLOCKS = ibvp_pkg::NUM_BLOCKS_DFLT
) (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          cfg_wr_en,
  input  logic [ibvp_pkg::LEN_W-1:0]    cfg_wr_data,

  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic                          command,
  input  logic [ibvp_pkg::ID_W-1:0]     block_id,
  input  logic [ibvp_pkg::SIZE_W-1:0]   block_size,
  input  logic [ibvp_pkg::SIZE_W-1:0]   edge_count,

  output logic                          rec_valid,
  input  logic                          rec_ready,
  output logic                          record_kind,
  output logic [ibvp_pkg::ID_W-1:0]     hit_block,
  output logic [ibvp_pkg::CNT_W-1:0]    hit_count,
  output logic [ibvp_pkg::CNT_W-1:0]    interval_number,
  output logic [ibvp_pkg::TOT_W-1:0]    insts_begin,
  output logic [ibvp_pkg::TOT_W-1:0]    insts_end,
  output logic [ibvp_pkg::TOT_W-1:0]    edges_begin,
  output logic [ibvp_pkg::TOT_W-1:0]    edges_end,
  output logic                          last
);

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam logic [AW-1:0] SCAN_LAST = AW'(NUM_BLOCKS - 1);

  ibvp_pkg::state_t   state, state_next;
  ibvp_pkg::hit_ctl_t ctl;

  logic [ibvp_pkg::LEN_W-1:0]  interval_length;
  logic [ibvp_pkg::CNT_W-1:0]  interval_insts;
  logic [ibvp_pkg::TOT_W-1:0]  insts_total;
  logic [ibvp_pkg::TOT_W-1:0]  edges_total;
  logic [ibvp_pkg::TOT_W-1:0]  edges_at_start;
  logic [ibvp_pkg::CNT_W-1:0]  interval_index;

  logic [AW-1:0]               blk;
  logic [ibvp_pkg::SIZE_W-1:0] size_q;
  logic [ibvp_pkg::SIZE_W-1:0] edges_q;
  logic [AW-1:0]               scan_idx;

  logic [AW-1:0]               addr;
  logic [ibvp_pkg::CNT_W-1:0]  rd_data;
  logic [ibvp_pkg::CNT_W-1:0]  hit_sum;
  logic [ibvp_pkg::TOT_W-1:0]  insts_end_next;

  logic id_ok;
  logic out_free;
  logic hit_nz;
  logic full;
  logic load_hit;
  logic load_trail;

  assign id_ok    = 32'(block_id) < NUM_BLOCKS;
  assign out_free = !rec_valid || rec_ready;
  assign hit_nz   = rd_data != '0;
  assign full     = interval_insts >= {1'b0, interval_length};
  assign hit_sum  = rd_data + ibvp_pkg::CNT_W'(size_q);
  assign insts_end_next = insts_total + ibvp_pkg::TOT_W'(interval_insts);

  ibvp_hits #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .AW         (AW)
  ) u_hits (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .addr    (addr),
    .wr_data (hit_sum),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ibvp_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (command == ibvp_pkg::CMD_FLUSH) begin
            state_next = ibvp_pkg::ST_SCAN_RD;
          end else if (id_ok) begin
            state_next = ibvp_pkg::ST_ADD;
          end
        end
      end
      ibvp_pkg::ST_ADD: begin
        state_next = ibvp_pkg::ST_CHECK;
      end
      ibvp_pkg::ST_CHECK: begin
        state_next = full ? ibvp_pkg::ST_SCAN_RD : ibvp_pkg::ST_IDLE;
      end
      ibvp_pkg::ST_SCAN_RD: begin
        state_next = ibvp_pkg::ST_SCAN_CHK;
      end
      ibvp_pkg::ST_SCAN_CHK: begin
        if (!hit_nz || out_free) begin
          state_next = (scan_idx == SCAN_LAST) ? ibvp_pkg::ST_TRAIL : ibvp_pkg::ST_SCAN_RD;
        end
      end
      ibvp_pkg::ST_TRAIL: begin
        if (out_free) begin
          state_next = ibvp_pkg::ST_IDLE;
        end
      end
      default: state_next = ibvp_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_ready  = 1'b0;
    ctl        = '0;
    addr       = scan_idx;
    load_hit   = 1'b0;
    load_trail = 1'b0;
    unique case (state)
      ibvp_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        addr      = AW'(block_id);
        ctl.rd    = cmd_valid && (command == ibvp_pkg::CMD_BLOCK) && id_ok;
      end
      ibvp_pkg::ST_ADD: begin
        addr   = blk;
        ctl.wr = 1'b1;
      end
      ibvp_pkg::ST_CHECK: begin
      end
      ibvp_pkg::ST_SCAN_RD: begin
        ctl.rd = 1'b1;
      end
      ibvp_pkg::ST_SCAN_CHK: begin
        load_hit = hit_nz && out_free;
        ctl.clr  = load_hit;
      end
      ibvp_pkg::ST_TRAIL: begin
        load_trail = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ibvp_pkg::ST_IDLE;
      interval_length <= ibvp_pkg::INTERVAL_LEN_RST;
      interval_insts  <= '0;
      insts_total     <= '0;
      edges_total     <= '0;
      edges_at_start  <= '0;
      interval_index  <= '0;
      scan_idx        <= '0;
      rec_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        interval_length <= cfg_wr_data;
      end
      if (state == ibvp_pkg::ST_ADD) begin
        interval_insts <= interval_insts + ibvp_pkg::CNT_W'(size_q);
        edges_total    <= edges_total + ibvp_pkg::TOT_W'(edges_q);
      end
      if (state_next == ibvp_pkg::ST_SCAN_RD && state != ibvp_pkg::ST_SCAN_CHK) begin
        scan_idx <= '0;
      end else if (state == ibvp_pkg::ST_SCAN_CHK && state_next != ibvp_pkg::ST_SCAN_CHK) begin
        scan_idx <= scan_idx + AW'(1);
      end
      if (load_trail) begin
        insts_total    <= insts_end_next;
        edges_at_start <= edges_total;
        interval_insts <= '0;
        interval_index <= interval_index + 32'd1;
      end
      if (load_hit || load_trail) begin
        rec_valid <= 1'b1;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      blk     <= AW'(block_id);
      size_q  <= block_size;
      edges_q <= edge_count;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_hit) begin
      record_kind     <= ibvp_pkg::KIND_HIT;
      hit_block       <= ibvp_pkg::ID_W'(scan_idx);
      hit_count       <= rd_data;
      interval_number <= '0;
      insts_begin     <= '0;
      insts_end       <= '0;
      edges_begin     <= '0;
      edges_end       <= '0;
      last            <= 1'b0;
    end else if (load_trail) begin
      record_kind     <= ibvp_pkg::KIND_TRAILER;
      hit_block       <= '0;
      hit_count       <= '0;
      interval_number <= interval_index;
      insts_begin     <= insts_total;
      insts_end       <= insts_end_next;
      edges_begin     <= edges_at_start;
      edges_end       <= edges_total;
      last            <= 1'b1;
    end
  end

endmodule

// ===== verif/tb_interval_block_vector_profiler_top.sv =====
`timescale 1ns / 100ps

module tb_interval_block_vector_profiler_top;

  localparam int LEN_W  = ibvp_pkg::LEN_W;
  localparam int CNT_W  = ibvp_pkg::CNT_W;
  localparam int TOT_W  = ibvp_pkg::TOT_W;
  localparam int ID_W   = ibvp_pkg::ID_W;
  localparam int SIZE_W = ibvp_pkg::SIZE_W;

  localparam int NBLK         = ibvp_pkg::NUM_BLOCKS_DFLT;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RAND_PER_PHASE = 25;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef struct packed {
    logic             kind;
    logic [ID_W-1:0]  blk;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] ivl_num;
    logic [TOT_W-1:0] ins_b;
    logic [TOT_W-1:0] ins_e;
    logic [TOT_W-1:0] edg_b;
    logic [TOT_W-1:0] edg_e;
    logic             lst;
  } profile_rec_t;

  // Tracks the per-block counters and interval totals, and queues the dump
  // records each accepted request should produce.
  class profile_tracker;
    logic [CNT_W-1:0] hits [NBLK];
    logic [CNT_W-1:0] ivl_insts;
    logic [TOT_W-1:0] insts_base;
    logic [TOT_W-1:0] edges_sum;
    logic [TOT_W-1:0] edges_base;
    logic [CNT_W-1:0] ivl_idx;
    logic [LEN_W-1:0] ivl_len;
    profile_rec_t     pending_records [$];
    int               errors;

    function new();
      foreach (hits[b]) hits[b] = '0;
      ivl_insts  = '0;
      insts_base = '0;
      edges_sum  = '0;
      edges_base = '0;
      ivl_idx    = '0;
      ivl_len    = ibvp_pkg::INTERVAL_LEN_RST;
      errors     = 0;
    endfunction

    function void set_length(logic [LEN_W-1:0] len);
      ivl_len = len;
    endfunction

    function int pending();
      return pending_records.size();
    endfunction

    function void close_interval();
      profile_rec_t r;
      for (int b = 0; b < NBLK; b++) begin
        if (hits[b] != '0) begin
          r = '0;
          r.kind  = ibvp_pkg::KIND_HIT;
          r.blk   = b[ID_W-1:0];
          r.count = hits[b];
          pending_records.push_back(r);
          hits[b] = '0;
        end
      end
      r = '0;
      r.kind    = ibvp_pkg::KIND_TRAILER;
      r.ivl_num = ivl_idx;
      r.ins_b   = insts_base;
      r.ins_e   = insts_base + TOT_W'(ivl_insts);
      r.edg_b   = edges_base;
      r.edg_e   = edges_sum;
      r.lst     = 1'b1;
      pending_records.push_back(r);
      edges_base = edges_sum;
      insts_base = insts_base + TOT_W'(ivl_insts);
      ivl_insts  = '0;
      ivl_idx    = ivl_idx + CNT_W'(1);
    endfunction

    function void note_request(logic cmd, logic [ID_W-1:0] id,
                               logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] edges);
      if (cmd == ibvp_pkg::CMD_FLUSH) begin
        close_interval();
        return;
      end
      if (int'(id) >= NBLK) return;
      hits[id]  = hits[id] + CNT_W'(size);
      ivl_insts = ivl_insts + CNT_W'(size);
      edges_sum = edges_sum + TOT_W'(edges);
      if (ivl_insts >= CNT_W'(ivl_len)) close_interval();
    endfunction

    function void check_field(string name, logic [TOT_W-1:0] exp_v,
                              logic [TOT_W-1:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_record(profile_rec_t got);
      profile_rec_t want;
      if (pending_records.size() == 0) begin
        errors++;
        $display("%0t: unexpected record, expected none, actual kind %0d block %0d",
                 $time, got.kind, got.blk);
        return;
      end
      want = pending_records.pop_front();
      check_field("record_kind", TOT_W'(want.kind), TOT_W'(got.kind));
      check_field("hit_block", TOT_W'(want.blk), TOT_W'(got.blk));
      check_field("hit_count", TOT_W'(want.count), TOT_W'(got.count));
      check_field("interval_number", TOT_W'(want.ivl_num), TOT_W'(got.ivl_num));
      check_field("insts_begin", want.ins_b, got.ins_b);
      check_field("insts_end", want.ins_e, got.ins_e);
      check_field("edges_begin", want.edg_b, got.edg_b);
      check_field("edges_end", want.edg_e, got.edg_e);
      check_field("last", TOT_W'(want.lst), TOT_W'(got.lst));
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [LEN_W-1:0]  cfg_wr_data;
  logic              cmd_valid;
  logic              cmd_ready;
  logic              command;
  logic [ID_W-1:0]   block_id;
  logic [SIZE_W-1:0] block_size;
  logic [SIZE_W-1:0] edge_count;
  logic              rec_valid;
  logic              rec_ready;
  logic              record_kind;
  logic [ID_W-1:0]   hit_block;
  logic [CNT_W-1:0]  hit_count;
  logic [CNT_W-1:0]  interval_number;
  logic [TOT_W-1:0]  insts_begin;
  logic [TOT_W-1:0]  insts_end;
  logic [TOT_W-1:0]  edges_begin;
  logic [TOT_W-1:0]  edges_end;
  logic              last;

  profile_tracker tracker;
  profile_rec_t   got_rec;
  int             send_idle_pct;
  int             recv_stall_pct;
  int             cycle_count;

  interval_block_vector_profiler_top u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .command         (command),
    .block_id        (block_id),
    .block_size      (block_size),
    .edge_count      (edge_count),
    .rec_valid       (rec_valid),
    .rec_ready       (rec_ready),
    .record_kind     (record_kind),
    .hit_block       (hit_block),
    .hit_count       (hit_count),
    .interval_number (interval_number),
    .insts_begin     (insts_begin),
    .insts_end       (insts_end),
    .edges_begin     (edges_begin),
    .edges_end       (edges_end),
    .last            (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("interval_block_vector_profiler_top verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    rec_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rec_valid && rec_ready) begin
      got_rec.kind    = record_kind;
      got_rec.blk     = hit_block;
      got_rec.count   = hit_count;
      got_rec.ivl_num = interval_number;
      got_rec.ins_b   = insts_begin;
      got_rec.ins_e   = insts_end;
      got_rec.edg_b   = edges_begin;
      got_rec.edg_e   = edges_end;
      got_rec.lst     = last;
      tracker.check_record(got_rec);
    end
  end

  // Returns at the rising edge that accepts the request; valid stays high.
  task automatic send_request(logic cmd, logic [ID_W-1:0] id,
                              logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] edges);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      cmd_valid = 1'b0;
    end
    @(negedge clk);
    cmd_valid  = 1'b1;
    command    = cmd;
    block_id   = id;
    block_size = size;
    edge_count = edges;
    do @(posedge clk); while (!cmd_ready);
    tracker.note_request(cmd, id, size, edges);
  endtask

  task automatic send_random_request();
    logic              cmd;
    logic [SIZE_W-1:0] size;
    cmd  = ($urandom_range(99) < 6) ? ibvp_pkg::CMD_FLUSH : ibvp_pkg::CMD_BLOCK;
    case ($urandom_range(9))
      0:       size = '0;
      1:       size = '1;
      default: size = SIZE_W'($urandom);
    endcase
    send_request(cmd, ID_W'($urandom), size, SIZE_W'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(logic [LEN_W-1:0] len);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = len;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    tracker.set_length(len);
  endtask

  initial begin
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    cmd_valid      = 1'b0;
    command        = ibvp_pkg::CMD_BLOCK;
    block_id       = '0;
    block_size     = '0;
    edge_count     = '0;
    rec_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycle_count    = 0;
    tracker        = new();
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: reset length first, empty flush gives a bare trailer
    send_request(ibvp_pkg::CMD_FLUSH, 5'd0, 8'd0, 8'd0);
    send_request(ibvp_pkg::CMD_BLOCK, 5'd0, 8'd255, 8'd255);
    send_request(ibvp_pkg::CMD_BLOCK, 5'd31, 8'd0, 8'd0);
    send_request(ibvp_pkg::CMD_BLOCK, 5'd31, 8'd1, 8'd1);
    send_request(ibvp_pkg::CMD_BLOCK, 5'd5, 8'd0, 8'd255);
    send_request(ibvp_pkg::CMD_FLUSH, 5'd31, 8'd255, 8'd255);

    // zero length: every block request dumps, even with zero size
    write_length('0);
    send_request(ibvp_pkg::CMD_BLOCK, 5'd17, 8'd200, 8'd7);
    send_request(ibvp_pkg::CMD_BLOCK, 5'd9, 8'd0, 8'd0);
    send_request(ibvp_pkg::CMD_FLUSH, 5'd17, 8'd1, 8'd1);

    write_length(31'd1);
    send_request(ibvp_pkg::CMD_BLOCK, 5'd3, 8'd0, 8'd100);
    send_request(ibvp_pkg::CMD_BLOCK, 5'd3, 8'd1, 8'd0);
    send_request(ibvp_pkg::CMD_BLOCK, 5'd30, 8'd255, 8'd255);

    write_length(LEN_MAX);
    repeat (3) send_request(ibvp_pkg::CMD_BLOCK, 5'd31, 8'd255, 8'd255);
    send_request(ibvp_pkg::CMD_FLUSH, 5'd0, 8'd0, 8'd0);

    // threshold hit exactly
    write_length(31'd255);
    send_request(ibvp_pkg::CMD_BLOCK, 5'd12, 8'd254, 8'd1);
    send_request(ibvp_pkg::CMD_BLOCK, 5'd13, 8'd1, 8'd1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_length(LEN_W'($urandom_range(200, 1500)));
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 0;
          write_length(LEN_W'($urandom_range(1, 300)));
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 77;
          write_length('0);
        end
        default: begin
          send_idle_pct  = 28;
          recv_stall_pct = 28;
          write_length(LEN_MAX);
          // every block hit, then a full dump
          for (int b = 0; b < NBLK; b++)
            send_request(ibvp_pkg::CMD_BLOCK, ID_W'(b), SIZE_W'($urandom_range(1, 255)),
                         SIZE_W'($urandom));
          send_request(ibvp_pkg::CMD_FLUSH, ID_W'($urandom), SIZE_W'($urandom),
                       SIZE_W'($urandom));
        end
      endcase
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (p == 1 && i == RAND_PER_PHASE / 2) wait_drained();
        send_random_request();
      end
    end

    wait_drained();
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("interval_block_vector_profiler_top verification clean");
    else
      $display("interval_block_vector_profiler_top verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/ibvp_pkg.sv
sv/ibvp_hits.sv
sv/interval_block_vector_profiler_top.sv
verif/tb_interval_block_vector_profiler_top.sv
